@@ rtl/ptc_pkg.sv @@
// Package for the 16-bit PWM timer/capture core: register addresses, command codes, mode families.
// No dependencies.
package ptc_pkg;
   localparam logic [7:0] ADDR_TIFR  = 8'h16;
   localparam logic [7:0] ADDR_TIMSK = 8'h4F;
   localparam logic [7:0] ADDR_TCCRA = 8'h60;
   localparam logic [7:0] ADDR_TCCRB = 8'h61;
   localparam logic [7:0] ADDR_TCCRC = 8'h62;
   localparam logic [7:0] ADDR_CNTL  = 8'h64;
   localparam logic [7:0] ADDR_CNTH  = 8'h65;
   localparam logic [7:0] ADDR_CAPL  = 8'h66;
   localparam logic [7:0] ADDR_CAPH  = 8'h67;
   localparam logic [7:0] ADDR_OCAL  = 8'h68;
   localparam logic [7:0] ADDR_OCAH  = 8'h69;
   localparam logic [7:0] ADDR_OCBL  = 8'h6A;
   localparam logic [7:0] ADDR_OCBH  = 8'h6B;

   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   typedef enum logic [1:0] {
      FAM_PLAIN = 2'd0,
      FAM_PC    = 2'd1,
      FAM_PFC   = 2'd2,
      FAM_FAST  = 2'd3
   } family_type;

   function automatic family_type family_of(input logic [3:0] wgm);
      case (wgm)
         4'd1, 4'd2, 4'd3, 4'd10, 4'd11: family_of = FAM_PC;
         4'd5, 4'd6, 4'd7, 4'd14, 4'd15: family_of = FAM_FAST;
         4'd8, 4'd9:                     family_of = FAM_PFC;
         default:                        family_of = FAM_PLAIN;
      endcase
   endfunction

   function automatic logic apply_mode(input logic lvl, input logic [1:0] mode);
      case (mode)
         2'd1:    apply_mode = ~lvl;
         2'd2:    apply_mode = 1'b0;
         2'd3:    apply_mode = 1'b1;
         default: apply_mode = lvl;
      endcase
   endfunction
endpackage

@@ rtl/pwm_timer_16bit_capture_core.sv @@
// Top level of the 16-bit PWM timer/capture core: timer state and result register.
// Depends on ptc_pkg.
//
// Channel  Dir  Contents
// req_     in   request: bus access, pin levels, flag acknowledges
// rsp_     out  result: read data, pin drive, interrupts, counter value
//
// One request per clock; its result is registered and appears the next cycle.
// Throughput is one request per cycle while req_tready is high, that is, unless a result waits.
// req_tready is low only while a result waits and rsp_tready is low.
// Synchronous reset clears all timer state and the result valid.
module pwm_timer_16bit_capture_core
   import ptc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[1:0], addr[9:2], wdata[17:10], t1_pin[18], icp_pin[19],
   // ack_capture[20], ack_match_a[21], ack_match_b[22], ack_overflow[23]
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0], wave_a[8], wave_a_enable[9], wave_b[10], wave_b_enable[11],
   // irq_capture[12], irq_match_a[13], irq_match_b[14], irq_overflow[15],
   // counter_value[31:16]
   output logic [31:0] rsp_tdata
);
   logic [9:0]  prescale_ff, prescale_in;
   logic [15:0] count_ff, count_in, mact_a_ff, mact_a_in, mbuf_a_ff, mbuf_a_in;
   logic [15:0] mact_b_ff, mact_b_in, mbuf_b_ff, mbuf_b_in, cap_ff, cap_in;
   logic [3:0]  pmodes_ff, pmodes_in, wgm_ff, wgm_in;
   logic [2:0]  cs_ff, cs_in, masks_ff, masks_in, flags_ff, flags_in;
   logic        icnc_ff, icnc_in, ices_ff, ices_in, icie_ff, icie_in, icf_ff, icf_in;
   logic        down_ff, down_in, blk_ff, blk_in, pa_ff, pa_in, pb_ff, pb_in;
   logic [7:0]  temp_ff, temp_in;
   logic [2:0]  esync_ff, esync_in;
   logic [3:0]  samp_ff, samp_in;
   logic        clean_ff, clean_in, prev_ff, prev_in;
   logic        rv_ff;
   logic [31:0] rsp_ff, rsp_in;

   logic [1:0]  cmd;
   logic [7:0]  addr, wdata, rd;
   logic        t1, icp, ack_c, ack_a, ack_b, ack_o, we, re, fire;
   family_type  fam, nfam;
   logic        dual, pwm, ck, at_top, at_bot, ev_ovf, ev_a, ev_b, ev_upd, filt, wf;
   logic [15:0] top, full;
   logic [1:0]  ma, mb, edg, na, nb;

   assign cmd   = req_tdata[1:0];
   assign addr  = req_tdata[9:2];
   assign wdata = req_tdata[17:10];
   assign t1    = req_tdata[18];
   assign icp   = req_tdata[19];
   assign ack_c = req_tdata[20];
   assign ack_a = req_tdata[21];
   assign ack_b = req_tdata[22];
   assign ack_o = req_tdata[23];

   assign req_tready = ~rv_ff | rsp_tready;
   assign fire       = req_tvalid & req_tready;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rsp_ff;

   // Compute the next timer state for one request
   always_comb begin
      we  = cmd == CMD_WRITE;
      re  = cmd == CMD_READ;
      fam = family_of(wgm_ff);
      dual = fam == FAM_PC || fam == FAM_PFC;
      pwm  = fam != FAM_PLAIN;
      ma  = pmodes_ff[3:2];
      mb  = pmodes_ff[1:0];
      edg = esync_ff[2:1];
      case (cs_ff)
         3'd1:    ck = 1'b1;
         3'd2:    ck = &prescale_ff[2:0];
         3'd3:    ck = &prescale_ff[5:0];
         3'd4:    ck = &prescale_ff[7:0];
         3'd5:    ck = &prescale_ff;
         3'd6:    ck = edg == 2'd2;
         3'd7:    ck = edg == 2'd1;
         default: ck = 1'b0;
      endcase
      case (wgm_ff)
         4'd1, 4'd5:                top = 16'h00FF;
         4'd2, 4'd6:                top = 16'h01FF;
         4'd3, 4'd7:                top = 16'h03FF;
         4'd4, 4'd9, 4'd11, 4'd15:  top = mact_a_ff;
         4'd8, 4'd10, 4'd12, 4'd14: top = cap_ff;
         default:                   top = 16'hFFFF;
      endcase
      // Read mux on pre-update state
      case (addr)
         ADDR_TIFR:  rd = {2'b00, icf_ff, 2'b00, flags_ff};
         ADDR_TIMSK: rd = {2'b00, icie_ff, 2'b00, masks_ff};
         ADDR_TCCRA: rd = {pmodes_ff, 2'b00, wgm_ff[1:0]};
         ADDR_TCCRB: rd = {icnc_ff, ices_ff, 1'b0, wgm_ff[3:2], cs_ff};
         ADDR_CNTL:  rd = count_ff[7:0];
         ADDR_CAPL:  rd = cap_ff[7:0];
         ADDR_OCAL:  rd = mbuf_a_ff[7:0];
         ADDR_OCBL:  rd = mbuf_b_ff[7:0];
         ADDR_CNTH, ADDR_CAPH, ADDR_OCAH, ADDR_OCBH: rd = temp_ff;
         default:    rd = 8'h00;
      endcase
      at_top = count_ff == top;
      at_bot = count_ff == 16'h0000;
      ev_ovf = ck & (dual ? (down_ff & at_bot)
                          : (fam == FAM_FAST ? at_top : (count_ff == 16'hFFFF)));
      ev_a = ck & ~blk_ff & (count_ff == mact_a_ff);
      ev_b = ck & ~blk_ff & (count_ff == mact_b_ff);
      ev_upd = ck & ((fam == FAM_PC || fam == FAM_FAST) ? at_top
                     : (fam == FAM_PFC) ? (down_ff & at_bot) : 1'b0);

      prescale_in = prescale_ff + 10'd1;
      esync_in = {esync_ff[1:0], t1};
      count_in = count_ff; down_in = down_ff; blk_in = blk_ff;
      mact_a_in = mact_a_ff; mact_b_in = mact_b_ff;
      mbuf_a_in = mbuf_a_ff; mbuf_b_in = mbuf_b_ff; cap_in = cap_ff;
      pmodes_in = pmodes_ff; wgm_in = wgm_ff; cs_in = cs_ff;
      icnc_in = icnc_ff; ices_in = ices_ff; icie_in = icie_ff; masks_in = masks_ff;
      icf_in = icf_ff; flags_in = flags_ff; pa_in = pa_ff; pb_in = pb_ff;
      temp_in = temp_ff;

      // Advance the counter
      if (ck) begin
         if (dual) begin
            if (down_ff) begin
               if (at_bot) begin
                  down_in = 1'b0;
                  count_in = (top == 16'h0000) ? 16'h0000 : 16'h0001;
               end else count_in = count_ff - 16'd1;
            end else begin
               if (at_top) begin
                  down_in = 1'b1;
                  count_in = (top == 16'h0000) ? 16'h0000 : count_ff - 16'd1;
               end else count_in = count_ff + 16'd1;
            end
         end else begin
            count_in = at_top ? 16'h0000 : count_ff + 16'd1;
         end
         blk_in = 1'b0;
      end
      if (ev_upd) begin
         mact_a_in = mbuf_a_ff;
         mact_b_in = mbuf_b_ff;
      end

      // Capture input filter and edge detect
      clean_in = clean_ff;
      if (samp_ff == 4'hF) clean_in = 1'b1;
      if (samp_ff == 4'h0) clean_in = 1'b0;
      filt = icnc_ff ? clean_ff : samp_ff[1];
      wf = we && addr == ADDR_TIFR;
      if (filt != prev_ff && filt == ices_ff) begin
         cap_in = count_ff;
         icf_in = 1'b1;
      end else if (ack_c || (wf && wdata[5])) icf_in = 1'b0;
      prev_in = filt;
      samp_in = {samp_ff[2:0], icp};

      // Waveform pins
      if (!pwm) begin
         if (ev_a || (we && addr == ADDR_TCCRC && wdata[7])) pa_in = apply_mode(pa_ff, ma);
         if (ev_b || (we && addr == ADDR_TCCRC && wdata[6])) pb_in = apply_mode(pb_ff, mb);
      end else if (fam == FAM_FAST) begin
         if (ck && at_top) begin
            if (ma == 2'd2) pa_in = 1'b1;
            if (ma == 2'd3) pa_in = 1'b0;
            if (mb == 2'd2) pb_in = 1'b1;
            if (mb == 2'd3) pb_in = 1'b0;
         end else begin
            if (ev_a) pa_in = apply_mode(pa_ff, ma);
            if (ev_b && mb[1]) pb_in = apply_mode(pb_ff, mb);
         end
      end else begin
         if (ev_a) begin
            if (ma == 2'd1) pa_in = ~pa_ff;
            else if (ma == 2'd2) pa_in = down_ff;
            else if (ma == 2'd3) pa_in = ~down_ff;
         end
         if (ev_b) begin
            if (mb == 2'd2) pb_in = down_ff;
            else if (mb == 2'd3) pb_in = ~down_ff;
         end
      end

      // Event flags: setting wins over clearing
      if (ev_ovf) flags_in[0] = 1'b1;
      else if (ack_o || (wf && wdata[0])) flags_in[0] = 1'b0;
      if (ev_a) flags_in[1] = 1'b1;
      else if (ack_a || (wf && wdata[1])) flags_in[1] = 1'b0;
      if (ev_b) flags_in[2] = 1'b1;
      else if (ack_b || (wf && wdata[2])) flags_in[2] = 1'b0;

      // Register writes
      full = {temp_ff, wdata};
      if (we) begin
         case (addr)
            ADDR_TCCRA: begin
               pmodes_in = wdata[7:4];
               wgm_in = {wgm_ff[3:2], wdata[1:0]};
            end
            ADDR_TCCRB: begin
               icnc_in = wdata[7];
               ices_in = wdata[6];
               wgm_in = {wdata[4:3], wgm_ff[1:0]};
               cs_in = wdata[2:0];
            end
            ADDR_TIMSK: begin
               icie_in = wdata[5];
               masks_in = wdata[2:0];
            end
            ADDR_CNTH, ADDR_CAPH, ADDR_OCAH, ADDR_OCBH: temp_in = wdata;
            ADDR_CNTL: begin
               count_in = full;
               blk_in = 1'b1;
            end
            ADDR_CAPL: cap_in = full;
            ADDR_OCAL: begin
               mbuf_a_in = full;
               if (fam == FAM_PLAIN) mact_a_in = full;
            end
            ADDR_OCBL: begin
               mbuf_b_in = full;
               if (fam == FAM_PLAIN) mact_b_in = full;
            end
            default: ;
         endcase
      end
      // Low-byte reads latch the high byte into TEMP
      if (re) begin
         case (addr)
            ADDR_CNTL: temp_in = count_ff[15:8];
            ADDR_CAPL: temp_in = cap_ff[15:8];
            ADDR_OCAL: temp_in = mbuf_a_ff[15:8];
            ADDR_OCBL: temp_in = mbuf_b_ff[15:8];
            default: ;
         endcase
      end

      // Result from the updated state, with read data taken from the pre-update state
      nfam = family_of(wgm_in);
      na = pmodes_in[3:2];
      nb = pmodes_in[1:0];
      rsp_in = {count_in,
                flags_in[0] & masks_in[0], flags_in[2] & masks_in[2],
                flags_in[1] & masks_in[1], icf_in & icie_in,
                (nb != 2'd0) && !(nfam != FAM_PLAIN && nb == 2'd1), pb_in,
                na != 2'd0, pa_in, rd};
   end

   // Hold state on idle cycles, update on an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0; count_ff <= '0; mact_a_ff <= '0; mbuf_a_ff <= '0;
         mact_b_ff <= '0; mbuf_b_ff <= '0; cap_ff <= '0; pmodes_ff <= '0;
         wgm_ff <= '0; cs_ff <= '0; icnc_ff <= 1'b0; ices_ff <= 1'b0;
         masks_ff <= '0; icie_ff <= 1'b0; flags_ff <= '0; icf_ff <= 1'b0;
         down_ff <= 1'b0; blk_ff <= 1'b0; pa_ff <= 1'b0; pb_ff <= 1'b0;
         temp_ff <= '0; esync_ff <= '0; samp_ff <= '0; clean_ff <= 1'b0;
         prev_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         if (fire) begin
            prescale_ff <= prescale_in; count_ff <= count_in; mact_a_ff <= mact_a_in;
            mbuf_a_ff <= mbuf_a_in; mact_b_ff <= mact_b_in; mbuf_b_ff <= mbuf_b_in;
            cap_ff <= cap_in; pmodes_ff <= pmodes_in; wgm_ff <= wgm_in; cs_ff <= cs_in;
            icnc_ff <= icnc_in; ices_ff <= ices_in; masks_ff <= masks_in;
            icie_ff <= icie_in; flags_ff <= flags_in; icf_ff <= icf_in;
            down_ff <= down_in; blk_ff <= blk_in; pa_ff <= pa_in; pb_ff <= pb_in;
            temp_ff <= temp_in; esync_ff <= esync_in; samp_ff <= samp_in;
            clean_ff <= clean_in; prev_ff <= prev_in;
         end
         if (fire) rv_ff <= 1'b1;
         else if (rsp_tready) rv_ff <= 1'b0;
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      if (fire) rsp_ff <= rsp_in;
   end
endmodule

@@ rtl/ptc_checker.sv @@
// Port-level checker for the 16-bit PWM timer/capture core, with its bind.
// Depends on pwm_timer_16bit_capture_core ports only.
module ptc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   // A stalled result holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
   // Every accepted request yields a result next cycle
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request without result");
   // Request side is open whenever the result side is free
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("request stalled with free output");
   // A result only appears after an accepted request
   a_src: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("result without request");
endmodule

bind pwm_timer_16bit_capture_core ptc_checker u_ptc_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
